@@ design/rfd_pkg.sv @@
// Package for the radar frame deframer: frame layout, register codes and reset values, counter type.
package rfd_pkg;

  localparam int PAYLOAD_BYTES = 24;
  localparam int HEADER_BYTES  = 4;
  localparam int VALUE_BYTES   = 8;
  localparam int FOOTER_BYTES  = 2;
  localparam int FRAME_BYTES   = HEADER_BYTES + PAYLOAD_BYTES + FOOTER_BYTES;
  localparam int CNT_W         = $clog2(FRAME_BYTES + 1);

  localparam int CFG_DATA_W = 32;

  localparam logic [31:0] HEADER_RESET = 32'h0003_FFAA;
  localparam logic [15:0] FOOTER_RESET = 16'hCC55;
  localparam logic [15:0] Y_OFFSET     = 16'h8000;

  typedef enum logic [0:0] {
    CFG_HEADER = 1'b0,
    CFG_FOOTER = 1'b1
  } cfg_idx_t;

  typedef logic [CNT_W-1:0] cnt_t;

endpackage

@@ design/rfd_rx_if.sv @@
// Byte channel carrying received serial bytes into the deframer.
interface rfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ design/rfd_frame_if.sv @@
// Result channel carrying one decoded frame per transaction.
interface rfd_frame_if;
  logic               valid;
  logic               ready;
  logic               frame_ok;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] target_speed;
  logic        [15:0] resolution;

  modport source (output valid, output frame_ok, output pos_x, output pos_y,
                  output target_speed, output resolution, input ready);
  modport sink   (input valid, input frame_ok, input pos_x, input pos_y,
                  input target_speed, input resolution, output ready);
endinterface

@@ design/radar_frame_deframer.sv @@
// Radar frame deframer top level: byte capture stage, frame tracker, result register.
// A closing footer byte is registered in the byte stage and then in the result register.
// Throughput: one byte per cycle; the byte stage moves whenever the result register
// is empty or being taken, so a held result stalls input only once both are full.
// Reset (rst, synchronous): hunting for a header, held values zero, registers at
// their reset values, both stages empty.
module radar_frame_deframer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [rfd_pkg::CFG_DATA_W-1:0]  cfg_data,
  rfd_rx_if.sink                          rx_ch,
  rfd_frame_if.source                     frame_ch
);

  // configuration
  logic [31:0] header_word;
  logic [15:0] footer_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_word <= rfd_pkg::HEADER_RESET;
      footer_word <= rfd_pkg::FOOTER_RESET;
    end else if (cfg_we) begin
      unique case (rfd_pkg::cfg_idx_t'(cfg_index))
        rfd_pkg::CFG_HEADER: header_word <= cfg_data[31:0];
        rfd_pkg::CFG_FOOTER: footer_word <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // byte capture stage
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_fire;
  logic       out_free;

  assign out_free    = !frame_ch.valid || frame_ch.ready;
  assign s1_fire     = s1_valid && out_free;
  assign rx_ch.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx_ch.valid && rx_ch.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_ch.valid && rx_ch.ready) begin
      s1_byte <= rx_ch.rx_byte;
    end
  end

  // frame tracker state
  logic                collecting, collecting_next;
  rfd_pkg::cnt_t       byte_count, byte_count_next;
  logic [3:0][7:0]     header_seen, header_seen_next;
  logic [7:0][7:0]     value_bytes, value_bytes_next;
  logic [1:0][7:0]     footer_seen, footer_seen_next;
  logic [15:0]         held_x, held_x_next;
  logic [15:0]         held_y, held_y_next;
  logic [15:0]         held_speed, held_speed_next;
  logic [15:0]         held_resolution, held_resolution_next;
  logic                emit;
  logic                ok;
  rfd_pkg::cnt_t       count_inc;
  rfd_pkg::cnt_t       pay_idx;
  rfd_pkg::cnt_t       foot_idx;

  always_comb begin
    collecting_next      = collecting;
    byte_count_next      = byte_count;
    header_seen_next     = header_seen;
    value_bytes_next     = value_bytes;
    footer_seen_next     = footer_seen;
    held_x_next          = held_x;
    held_y_next          = held_y;
    held_speed_next      = held_speed;
    held_resolution_next = held_resolution;
    emit                 = 1'b0;
    ok                   = 1'b0;
    count_inc            = byte_count + rfd_pkg::CNT_W'(1);
    pay_idx              = byte_count - rfd_pkg::CNT_W'(rfd_pkg::HEADER_BYTES);
    foot_idx             = byte_count
                           - rfd_pkg::CNT_W'(rfd_pkg::HEADER_BYTES + rfd_pkg::PAYLOAD_BYTES);
    if (s1_fire) begin
      if (!collecting) begin
        if (s1_byte == header_word[7:0]) begin
          collecting_next  = 1'b1;
          header_seen_next = {24'd0, s1_byte};
          value_bytes_next = '0;
          footer_seen_next = '0;
          byte_count_next  = rfd_pkg::CNT_W'(1);
        end
      end else begin
        if (byte_count < rfd_pkg::CNT_W'(rfd_pkg::HEADER_BYTES)) begin
          header_seen_next[byte_count[1:0]] = s1_byte;
        end else if (byte_count < rfd_pkg::CNT_W'(rfd_pkg::HEADER_BYTES
                                                 + rfd_pkg::PAYLOAD_BYTES)) begin
          if (pay_idx < rfd_pkg::CNT_W'(rfd_pkg::VALUE_BYTES)) begin
            value_bytes_next[pay_idx[2:0]] = s1_byte;
          end
        end else begin
          footer_seen_next[foot_idx[0]] = s1_byte;
        end
        byte_count_next = count_inc;
        if (count_inc == rfd_pkg::CNT_W'(rfd_pkg::FRAME_BYTES)) begin
          emit            = 1'b1;
          collecting_next = 1'b0;
          byte_count_next = '0;
          ok = (header_seen_next == header_word) && (footer_seen_next == footer_word);
          if (ok) begin
            held_x_next          = 16'(-{value_bytes_next[1], value_bytes_next[0]});
            held_y_next          = {value_bytes_next[3], value_bytes_next[2]}
                                   - rfd_pkg::Y_OFFSET;
            held_speed_next      = 16'(-{value_bytes_next[5], value_bytes_next[4]});
            held_resolution_next = {value_bytes_next[7], value_bytes_next[6]};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting      <= 1'b0;
      byte_count      <= '0;
      held_x          <= '0;
      held_y          <= '0;
      held_speed      <= '0;
      held_resolution <= '0;
    end else begin
      collecting      <= collecting_next;
      byte_count      <= byte_count_next;
      held_x          <= held_x_next;
      held_y          <= held_y_next;
      held_speed      <= held_speed_next;
      held_resolution <= held_resolution_next;
    end
  end

  always_ff @(posedge clk) begin
    header_seen <= header_seen_next;
    value_bytes <= value_bytes_next;
    footer_seen <= footer_seen_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_ch.valid <= 1'b0;
    end else if (emit) begin
      frame_ch.valid <= 1'b1;
    end else if (frame_ch.ready) begin
      frame_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      frame_ch.frame_ok     <= ok;
      frame_ch.pos_x        <= held_x_next;
      frame_ch.pos_y        <= held_y_next;
      frame_ch.target_speed <= held_speed_next;
      frame_ch.resolution   <= held_resolution_next;
    end
  end

  // checks
  a_hunt_count_zero: assert property (@(posedge clk) disable iff (rst)
    !collecting |-> byte_count == '0)
    else $error("byte count nonzero while hunting");

  a_emit_in_frame: assert property (@(posedge clk) disable iff (rst)
    emit |-> collecting && s1_fire)
    else $error("result produced outside a frame");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_byte))
    else $error("stalled byte lost from capture stage");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    frame_ch.valid && !frame_ch.ready |-> !emit)
    else $error("pending result overwritten");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for radar_frame_deframer: byte stream in, decoded frames out.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET    = 1050;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 400;
  localparam int MAX_PRINTS     = 40;

  typedef enum {FRM_GOOD, FRM_BAD_HDR, FRM_BAD_FTR} frame_kind_t;

  typedef struct {
    logic        ok;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] speed;
    logic [15:0] res;
  } frame_result_t;

  typedef logic [7:0] byte_q_t[$];

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic                           cfg_index = rfd_pkg::CFG_HEADER;
  logic [rfd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  rfd_rx_if    rx_bus();
  rfd_frame_if frame_bus();

  radar_frame_deframer dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .rx_ch    (rx_bus),
    .frame_ch (frame_bus)
  );

  always #5 clk = ~clk;

  // Deframer prediction state, kept in step with every accepted byte.
  logic [31:0] hdr_cfg = rfd_pkg::HEADER_RESET;
  logic [15:0] ftr_cfg = rfd_pkg::FOOTER_RESET;
  logic        in_frame = 1'b0;
  int          frame_pos = 0;
  logic [31:0] hdr_acc = '0;
  logic [63:0] raw_vals = '0;
  logic [15:0] ftr_acc = '0;
  logic [15:0] held_x = '0;
  logic [15:0] held_y = '0;
  logic [15:0] held_speed = '0;
  logic [15:0] held_res = '0;

  frame_result_t frames_due[$];
  byte_q_t       pending_bytes;

  int mismatches = 0;
  int bytes_taken = 0;
  int frames_seen = 0;
  int frames_matched = 0;
  int reg_writes = 0;
  int frames_queued = 0;
  int idle_cycles = 0;

  // Sender burst/gap and receiver stall pattern state.
  int burst_left = 8;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_timer = 0;
  int run_left = 0;
  logic run_val = 1'b1;

  function automatic void deframe_byte(input logic [7:0] b);
    frame_result_t r;
    int idx;
    if (!in_frame) begin
      if (b == hdr_cfg[7:0]) begin
        in_frame = 1'b1;
        hdr_acc = {24'h0, b};
        raw_vals = '0;
        ftr_acc = '0;
        frame_pos = 1;
      end
      return;
    end
    idx = frame_pos;
    if (idx < rfd_pkg::HEADER_BYTES)
      hdr_acc[8*idx +: 8] = b;
    else if (idx < rfd_pkg::HEADER_BYTES + rfd_pkg::PAYLOAD_BYTES) begin
      if (idx - rfd_pkg::HEADER_BYTES < rfd_pkg::VALUE_BYTES)
        raw_vals[8*(idx - rfd_pkg::HEADER_BYTES) +: 8] = b;
    end else
      ftr_acc[8*(idx - rfd_pkg::HEADER_BYTES - rfd_pkg::PAYLOAD_BYTES) +: 8] = b;
    frame_pos = idx + 1;
    if (frame_pos < rfd_pkg::FRAME_BYTES)
      return;
    in_frame = 1'b0;
    frame_pos = 0;
    r.ok = (hdr_acc == hdr_cfg) && (ftr_acc == ftr_cfg);
    if (r.ok) begin
      held_x     = 16'h0 - raw_vals[15:0];
      held_y     = raw_vals[31:16] - rfd_pkg::Y_OFFSET;
      held_speed = 16'h0 - raw_vals[47:32];
      held_res   = raw_vals[63:48];
    end
    r.x = held_x;
    r.y = held_y;
    r.speed = held_speed;
    r.res = held_res;
    frames_due.push_back(r);
  endfunction

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    if (mismatches < MAX_PRINTS)
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic void build_frame(output byte_q_t f, input logic [31:0] hdr,
                                      input logic [15:0] ftr, input logic [63:0] vals);
    f = {};
    for (int k = 0; k < rfd_pkg::HEADER_BYTES; k++)
      f.push_back(hdr[8*k +: 8]);
    for (int p = 0; p < rfd_pkg::PAYLOAD_BYTES; p++)
      f.push_back(p < rfd_pkg::VALUE_BYTES ? vals[8*p +: 8] : 8'($urandom()));
    for (int k = 0; k < rfd_pkg::FOOTER_BYTES; k++)
      f.push_back(ftr[8*k +: 8]);
  endfunction

  task automatic queue_frame(input frame_kind_t kind, input logic [63:0] vals);
    byte_q_t f;
    int k;
    build_frame(f, hdr_cfg, ftr_cfg, vals);
    case (kind)
      FRM_BAD_HDR: begin
        k = $urandom_range(1, rfd_pkg::HEADER_BYTES - 1);
        f[k] = f[k] ^ 8'($urandom_range(1, 255));
      end
      FRM_BAD_FTR: begin
        k = rfd_pkg::FRAME_BYTES - 1 - $urandom_range(0, rfd_pkg::FOOTER_BYTES - 1);
        f[k] = f[k] ^ 8'($urandom_range(1, 255));
      end
      default: ;
    endcase
    foreach (f[i]) pending_bytes.push_back(f[i]);
    frames_queued++;
  endtask

  // Noise between frames; mostly avoids the frame start byte so alignment holds.
  task automatic queue_noise(input int count);
    logic [7:0] b;
    repeat (count) begin
      b = 8'($urandom());
      if (b == hdr_cfg[7:0] && $urandom_range(0, 7) != 0)
        b = ~b;
      pending_bytes.push_back(b);
    end
  endtask

  // Wait until every byte is taken and every frame returned, then let the pipe drain.
  task automatic settle();
    @(negedge clk);
    while (pending_bytes.size() != 0 || rx_bus.valid || frames_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input rfd_pkg::cfg_idx_t idx,
                           input logic [rfd_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rfd_pkg::CFG_HEADER: hdr_cfg = val[31:0];
      rfd_pkg::CFG_FOOTER: ftr_cfg = val[15:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin : drive_rx
    logic       took;
    logic       nxt_valid;
    logic [7:0] nxt_byte;
    if (rst) begin
      rx_bus.valid <= 1'b0;
    end else begin
      took = rx_bus.valid && rx_bus.ready;
      if (took) begin
        deframe_byte(rx_bus.rx_byte);
        bytes_taken++;
      end
      nxt_valid = rx_bus.valid && !took;
      nxt_byte  = rx_bus.rx_byte;
      if (!nxt_valid) begin
        if (gap_left > 0)
          gap_left--;
        else if (pending_bytes.size() > 0) begin
          nxt_valid = 1'b1;
          nxt_byte  = pending_bytes.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      rx_bus.valid   <= nxt_valid;
      rx_bus.rx_byte <= nxt_byte;
    end
  end

  // Receiver: switches between always ready, random ready and long stall runs.
  always @(posedge clk) begin : drive_ready
    logic nxt_ready;
    if (stall_timer == 0) begin
      stall_mode  = $urandom_range(0, 2);
      stall_timer = $urandom_range(50, 200);
    end else
      stall_timer--;
    case (stall_mode)
      0: nxt_ready = 1'b1;
      1: nxt_ready = 1'($urandom_range(0, 1));
      default: begin
        if (run_left == 0) begin
          run_val  = !run_val;
          run_left = run_val ? $urandom_range(1, 6) : $urandom_range(1, 15);
        end else
          run_left--;
        nxt_ready = run_val;
      end
    endcase
    frame_bus.ready <= nxt_ready;
  end

  always @(posedge clk) begin : check_frames
    frame_result_t want;
    if (!rst && frame_bus.valid && frame_bus.ready) begin
      frames_seen++;
      if (frame_bus.frame_ok === 1'b1)
        frames_matched++;
      if (frames_due.size() == 0)
        report("frame with none pending, frame_ok", {15'h0, frame_bus.frame_ok}, 16'h0);
      else begin
        want = frames_due.pop_front();
        if (frame_bus.frame_ok !== want.ok)
          report("frame_ok", {15'h0, frame_bus.frame_ok}, {15'h0, want.ok});
        if (frame_bus.pos_x !== want.x)
          report("pos_x", frame_bus.pos_x, want.x);
        if (frame_bus.pos_y !== want.y)
          report("pos_y", frame_bus.pos_y, want.y);
        if (frame_bus.target_speed !== want.speed)
          report("target_speed", frame_bus.target_speed, want.speed);
        if (frame_bus.resolution !== want.res)
          report("resolution", frame_bus.resolution, want.res);
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (!rst) begin
      if ((rx_bus.valid && rx_bus.ready) || (frame_bus.valid && frame_bus.ready))
        idle_cycles = 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end else
        idle_cycles++;
    end
  end

  initial begin : stimulus
    byte_q_t     f;
    frame_kind_t kind;
    int          phase;
    rx_bus.valid    = 1'b0;
    rx_bus.rx_byte  = 8'h00;
    frame_bus.ready = 1'b0;

    // Directed part, reset register values.
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h55);
    queue_frame(FRM_GOOD, {16'hFFFF, 16'h8000, 16'h0000, 16'h0000});
    queue_frame(FRM_GOOD, {16'h0000, 16'h0001, 16'hFFFF, 16'h8000});
    queue_frame(FRM_GOOD, {16'h1234, 16'h7FFF, 16'h8000, 16'hFFFF});
    queue_frame(FRM_BAD_HDR, {16'h1111, 16'h2222, 16'h3333, 16'h4444});
    queue_frame(FRM_BAD_FTR, {16'h5555, 16'h6666, 16'h7777, 16'h0123});
    // Value bytes all frame start bytes: no resync inside a frame.
    queue_frame(FRM_GOOD, {4{hdr_cfg[7:0], hdr_cfg[7:0]}});
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    settle();

    // Header changes while a frame is open: final compare uses the new word.
    build_frame(f, hdr_cfg, ftr_cfg, {16'hA5A5, 16'h5A5A, 16'h0F0F, 16'hF0F0});
    for (int i = 0; i < 12; i++) pending_bytes.push_back(f[i]);
    settle();
    write_reg(rfd_pkg::CFG_HEADER, 32'h1234_5678);
    for (int i = 12; i < rfd_pkg::FRAME_BYTES; i++) pending_bytes.push_back(f[i]);
    settle();

    // Footer changes while a frame is open; frame carries the new footer.
    build_frame(f, hdr_cfg, 16'h0F1E, {16'h0002, 16'hFFFE, 16'h7FFE, 16'h8001});
    for (int i = 0; i < 20; i++) pending_bytes.push_back(f[i]);
    settle();
    write_reg(rfd_pkg::CFG_FOOTER, {16'hBEEF, 16'h0F1E});
    for (int i = 20; i < rfd_pkg::FRAME_BYTES; i++) pending_bytes.push_back(f[i]);
    settle();

    // Random part: one register setting per phase, extremes first.
    phase = 0;
    while (bytes_taken < ITEM_TARGET) begin
      case (phase)
        0: begin
          write_reg(rfd_pkg::CFG_HEADER, 32'hFFFF_FFFF);
          write_reg(rfd_pkg::CFG_FOOTER, 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(rfd_pkg::CFG_HEADER, 32'h0000_0000);
          write_reg(rfd_pkg::CFG_FOOTER, 32'h0000_0000);
        end
        2: begin
          write_reg(rfd_pkg::CFG_HEADER, {16'h0003, 16'hFFAA});
          write_reg(rfd_pkg::CFG_FOOTER, {16'($urandom()), rfd_pkg::FOOTER_RESET});
        end
        default: begin
          write_reg(rfd_pkg::CFG_HEADER, 32'($urandom()));
          write_reg(rfd_pkg::CFG_FOOTER, 32'($urandom()));
        end
      endcase
      repeat (7) begin
        queue_noise($urandom_range(0, 4));
        kind = ($urandom_range(0, 9) < 8) ? FRM_GOOD :
               ($urandom_range(0, 1) ? FRM_BAD_HDR : FRM_BAD_FTR);
        queue_frame(kind, {pick_word(), pick_word(), pick_word(), pick_word()});
      end
      settle();
      phase++;
    end

    $display("Run covered %0d bytes in, %0d frames out (%0d matched), %0d register writes",
             bytes_taken, frames_seen, frames_matched, reg_writes);
    $display("Register settings used: %0d random phases after the directed frames", phase);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
design/rfd_pkg.sv
design/rfd_rx_if.sv
design/rfd_frame_if.sv
design/radar_frame_deframer.sv
tb/testbench.sv
